### src/ors_pkg.sv
`timescale 1ns / 1ps

package ors_pkg;

    // Identifier width and the bit index width into a set bitmap of that width
    localparam int ID_W    = 63;
    localparam int IDX_W   = $clog2(ID_W);
    localparam int TDATA_W = ((ID_W + 7) / 8) * 8;

    // Largest offset a set bitmap holds above its base point (1 .. ID_W-2)
    localparam int SET_SPAN = 61;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_RANGE = 2'd1,
        KIND_SET   = 2'd2
    } t_kind;

    // One record word on its way out
    typedef struct packed {
        t_kind           kind;
        logic [ID_W-1:0] value;
        logic            last;
    } t_word;

    // Words produced by one identifier: cnt of them, w0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_word      w0;
        t_word      w1;
    } t_push;

endpackage

### src/ors_core.sv
`timescale 1ns / 1ps

module ors_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ors_pkg::ID_W-1:0]  i_id,
    input  logic                      i_eoc,
    input  logic [1:0]                i_space,
    output ors_pkg::t_push            o_push
);
    import ors_pkg::*;

    localparam logic [ID_W-1:0] SPAN_V = ID_W'(SET_SPAN);
    localparam logic [ID_W-1:0] ONE_V  = ID_W'(1);

    // Input register
    logic            r_in_valid;
    logic [ID_W-1:0] r_in_id;
    logic            r_in_eoc;

    // Encoder state
    logic            r_pvalid, n_pvalid;
    t_kind           r_pkind, n_pkind;
    logic [ID_W-1:0] r_pval, n_pval;
    logic [ID_W-1:0] r_base, n_base;
    logic            r_single, n_single;
    logic [ID_W-1:0] r_lastm, n_lastm;

    logic            go;
    logic            tw_valid;
    t_word           tw;
    t_word           fw;
    t_push           push;
    logic [ID_W:0]   p_inc;
    logic            is_next;
    logic [ID_W-1:0] pdiff;
    logic            p_gt;
    logic [ID_W-1:0] sdiff;
    logic            s_in_span;
    logic            s_dup;

    // Compares against the pending value and the set base
    always_comb begin
        p_inc     = {1'b0, r_pval} + {1'b0, ONE_V};
        is_next   = (p_inc == {1'b0, r_in_id});
        pdiff     = r_in_id - r_pval;
        p_gt      = (r_in_id > r_pval);
        sdiff     = r_in_id - r_base;
        s_in_span = (r_in_id > r_base) && (sdiff <= SPAN_V);
        s_dup     = r_pval[sdiff[IDX_W-1:0]];
    end

    // Next state and the transition word
    always_comb begin
        n_pvalid = r_pvalid;
        n_pkind  = r_pkind;
        n_pval   = r_pval;
        n_base   = r_base;
        n_single = r_single;
        n_lastm  = r_lastm;
        tw_valid = 1'b0;
        tw       = '{kind: KIND_POINT, value: r_pval, last: 1'b0};

        if (!r_pvalid) begin
            n_pvalid = 1'b1;
            n_pkind  = KIND_POINT;
            n_pval   = r_in_id;
            n_single = 1'b0;
        end else begin
            unique case (r_pkind)
                KIND_SET: begin
                    if (s_in_span && !s_dup) begin
                        n_pval   = r_pval | (ONE_V << sdiff[IDX_W-1:0]);
                        n_single = 1'b0;
                        n_lastm  = r_in_id;
                    end else begin
                        tw_valid = 1'b1;
                        if (r_single) begin
                            tw = '{kind: KIND_POINT, value: r_lastm, last: 1'b0};
                        end else begin
                            tw = '{kind: KIND_SET, value: r_pval, last: 1'b0};
                        end
                        n_pkind  = KIND_POINT;
                        n_pval   = r_in_id;
                        n_single = 1'b0;
                    end
                end
                KIND_RANGE: begin
                    if (is_next) begin
                        n_pval = r_in_id;
                    end else begin
                        tw_valid = 1'b1;
                        tw       = '{kind: KIND_RANGE, value: r_pval, last: 1'b0};
                        n_pkind  = KIND_POINT;
                        n_pval   = r_in_id;
                        n_single = 1'b0;
                    end
                end
                default: begin
                    tw_valid = 1'b1;
                    if (is_next) begin
                        tw      = '{kind: KIND_RANGE, value: r_pval, last: 1'b0};
                        n_pkind = KIND_RANGE;
                        n_pval  = r_in_id;
                    end else if (p_gt && (pdiff <= SPAN_V)) begin
                        n_base   = r_pval;
                        n_pkind  = KIND_SET;
                        n_pval   = ONE_V << pdiff[IDX_W-1:0];
                        n_single = 1'b1;
                        n_lastm  = r_in_id;
                    end else begin
                        n_pkind  = KIND_POINT;
                        n_pval   = r_in_id;
                        n_single = 1'b0;
                    end
                end
            endcase
        end

        // Flush word from the updated state; single-member set leaves as a point
        if (n_pkind == KIND_SET && n_single) begin
            fw = '{kind: KIND_POINT, value: n_lastm, last: 1'b1};
        end else begin
            fw = '{kind: n_pkind, value: n_pval, last: 1'b1};
        end

        if (r_in_eoc) begin
            n_pvalid = 1'b0;
            n_pkind  = KIND_POINT;
            n_pval   = '0;
            n_base   = '0;
            n_single = 1'b0;
            n_lastm  = '0;
        end

        if (tw_valid) begin
            push.w0  = tw;
            push.w1  = fw;
            push.cnt = 2'd1 + {1'b0, r_in_eoc};
        end else begin
            push.w0  = fw;
            push.w1  = fw;
            push.cnt = {1'b0, r_in_eoc};
        end
    end

    // Process only when the output queue takes every word of this identifier
    assign go      = r_in_valid && (push.cnt <= i_space);
    assign o_ready = !r_in_valid || go;

    always_comb begin
        o_push     = push;
        o_push.cnt = go ? push.cnt : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pvalid   <= 1'b0;
            r_pkind    <= KIND_POINT;
            r_pval     <= '0;
            r_base     <= '0;
            r_single   <= 1'b0;
            r_lastm    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (go) begin
                r_pvalid <= n_pvalid;
                r_pkind  <= n_pkind;
                r_pval   <= n_pval;
                r_base   <= n_base;
                r_single <= n_single;
                r_lastm  <= n_lastm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_id  <= i_id;
            r_in_eoc <= i_eoc;
        end
    end

endmodule

### src/ors_outq.sv
`timescale 1ns / 1ps

module ors_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ors_pkg::t_push  i_push,
    output logic [1:0]      o_space,
    output logic            o_valid,
    input  logic            i_ready,
    output ors_pkg::t_word  o_word
);
    import ors_pkg::*;

    // Two-entry result queue, head in r_q0
    logic [1:0] r_cnt, n_cnt;
    t_word      r_q0, n_q0;
    t_word      r_q1, n_q1;
    logic       pop;
    logic [1:0] kept;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_q0;
    assign o_space = 2'd2 - r_cnt + {1'b0, pop};

    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            n_q0 = r_q1;
            kept = r_cnt - 2'd1;
        end else begin
            kept = r_cnt;
        end
        // Append behind whatever stays
        unique case (kept)
            2'd0: begin
                n_q0 = i_push.w0;
                n_q1 = i_push.w1;
            end
            2'd1: begin
                n_q1 = i_push.w0;
            end
            default: begin
            end
        endcase
        n_cnt = kept + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

### src/oid_run_set_encoder.sv
`timescale 1ns / 1ps
// Channel   Dir  Word contents (tdata / tuser / tlast)
// s_axis    in   tdata[62:0] id_value, tdata[63] zero fill; tlast end_of_column
// m_axis    out  tdata[62:0] word_value, tdata[63] zero; tuser[1:0] word_kind;
//                tlast last_word
//
// One identifier enters per cycle while s_axis_tready is high. It is encoded
// in the cycle it sits in the input register, and its words (zero, one or two)
// land in the two-entry output queue once the queue has room for all of them;
// from there the first word shows on m_axis. A word-pair (flush behind a closed
// word) takes both queue slots, so the sustained input rate is one per cycle
// only while each identifier yields at most one word and m_axis_tready stays
// high. Synchronous active-low reset clears the encoder state and the queue.
// s_axis_tready follows m_axis_tready through the queue's free-slot count.

module oid_run_set_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ors_pkg::TDATA_W-1:0]  s_axis_tdata,   // [62:0] id_value
    input  logic                         s_axis_tlast,   // end_of_column
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ors_pkg::TDATA_W-1:0]  m_axis_tdata,   // [62:0] word_value
    output logic [1:0]                   m_axis_tuser,   // [1:0] word_kind
    output logic                         m_axis_tlast    // last_word
);
    import ors_pkg::*;

    t_push      push;
    t_word      head;
    logic [1:0] space;

    // Encode: input register, state update, word generation
    ors_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_id    (s_axis_tdata[ID_W-1:0]),
        .i_eoc   (s_axis_tlast),
        .i_space (space),
        .o_push  (push)
    );

    // Hold finished words until the sink takes them
    ors_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_word  (head)
    );

    assign m_axis_tdata = {{(TDATA_W-ID_W){1'b0}}, head.value};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
